// File: src/trap_vector_select_top_macros.svh
// Assertion macros for the trap vector select block
`ifndef TRAP_VECTOR_SELECT_TOP_MACROS_SVH
`define TRAP_VECTOR_SELECT_TOP_MACROS_SVH

// Same-cycle or fixed-delay implication, checked outside reset
`define TVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

// Next-cycle implication, checked outside reset
`define TVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tvs_pkg.sv
// Types, constants and codes shared by the trap vector select pipeline
package tvs_pkg;

    localparam int VADDR_BITS = 40;

    // Result kinds
    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_VECTOR = 2'd1;
    localparam logic [1:0] KIND_DEBUG  = 2'd2;
    localparam logic [1:0] KIND_RETURN = 2'd3;

    // System instruction codes
    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;
    localparam logic [11:0] SYS_SRET   = 12'h102;
    localparam logic [11:0] SYS_MRET   = 12'h302;
    localparam logic [11:0] SYS_DRET   = 12'h7b2;
    localparam logic [11:0] SYS_XRET   = 12'h702;

    // Privilege levels
    localparam logic [1:0] PRIV_USER    = 2'd0;
    localparam logic [1:0] PRIV_SUPER   = 2'd1;
    localparam logic [1:0] PRIV_MACHINE = 2'd3;

    // Cause codes: debug entry, breakpoint and environment call base
    localparam logic [7:0] CAUSE_DEBUG = 8'd14;
    localparam logic [7:0] CAUSE_BREAK = 8'd3;
    localparam logic [7:0] CAUSE_CALL_BASE = 8'd8;

    // Debug entry addresses
    localparam logic [63:0] DEBUG_ENTRY      = 64'h800;
    localparam logic [63:0] DEBUG_ENTRY_EXCP = 64'h808;

    // Debug control ebreak enable bits
    localparam int DCSR_EBREAK_M = 15;
    localparam int DCSR_EBREAK_S = 13;
    localparam int DCSR_EBREAK_U = 12;

    // Mode bits cleared from a trap vector
    localparam logic [63:0] MODE_MASK_VEC = 64'h0000_0000_0000_00fe;
    localparam logic [63:0] MODE_MASK_DIR = 64'h0000_0000_0000_0002;

    // Upper bits set when a supervisor vector is sign-extended
    localparam logic [63:0] SEXT_MASK = {64{1'b1}} << (VADDR_BITS - 1);

    // Configuration register indexes
    localparam logic [2:0] CFG_MTVEC   = 3'd0;
    localparam logic [2:0] CFG_STVEC   = 3'd1;
    localparam logic [2:0] CFG_MEDELEG = 3'd2;
    localparam logic [2:0] CFG_MIDELEG = 3'd3;
    localparam logic [2:0] CFG_DCSR    = 3'd4;
    localparam logic [2:0] CFG_RVC     = 3'd5;

    typedef struct packed {
        logic [63:0] held_cause;
        logic        sys_valid;
        logic [11:0] sys_code;
        logic [1:0]  priv_level;
        logic        in_debug;
        logic        stepped;
        logic [63:0] super_return_pc;
        logic [63:0] machine_return_pc;
        logic [63:0] debug_return_pc;
    } tvs_req_t;

    typedef struct packed {
        logic [63:0] redirect_target;
        logic [1:0]  target_kind;
    } tvs_rsp_t;

    typedef struct packed {
        logic [63:0] machine_trap_base;
        logic [63:0] super_trap_base;
        logic [63:0] exception_delegation;
        logic [63:0] interrupt_delegation;
        logic [31:0] debug_control;
        logic        compressed_enabled;
    } tvs_cfg_t;

    // Decode stage to vector stage
    typedef struct packed {
        logic        ret;
        logic        debug;
        logic        debug_excp;
        logic        intr;
        logic        may_delegate;
        logic [7:0]  lsbs;
        logic [63:0] ret_target;
    } tvs_s1_t;

    // Vector stage to resolve stage
    typedef struct packed {
        logic        ret;
        logic        debug;
        logic        debug_excp;
        logic        vec_ok;
        logic [5:0]  vec_code;
        logic [63:0] addr;
    } tvs_s2_t;

endpackage

// File: src/trap_vector_select_top.sv
// Top level of the trap vector select block: config registers and three-stage pipeline
//
// Usage:
//   Request channel: drive request and raise start; a transfer happens at each
//   rising edge with start high and busy low. busy is always low, so a new
//   request may be issued in every cycle.
//   Result channel: done is high for exactly one cycle with result holding the
//   redirect target and its kind. The receiver cannot stall; it must take the
//   result in that cycle.
//   Config channel: cfg_valid with cfg_index and cfg_data; a write transfer
//   happens when cfg_valid and cfg_ready are high. cfg_ready is always high.
//   Indexes beyond the register list are ignored. Write only while idle.
//   Path: a request taken at an edge passes the decode, vector lookup and
//   resolve registers in turn, then raises done. Throughput: one per cycle,
//   set by the three register stages that each item passes once.
//   Reset: all config registers clear except compressed_enabled, which sets;
//   the pipeline valid bits clear, so no result is produced until a request.
`include "trap_vector_select_top_macros.svh"

module trap_vector_select_top
    import tvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tvs_req_t    request,
    output logic        done,
    output tvs_rsp_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    tvs_cfg_t cfg_reg;
    logic     accept;
    logic     s1_valid;
    tvs_s1_t  s1_data;
    logic     s2_valid;
    tvs_s2_t  s2_data;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Hold the configuration registers; update on a write transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.machine_trap_base    <= '0;
            cfg_reg.super_trap_base      <= '0;
            cfg_reg.exception_delegation <= '0;
            cfg_reg.interrupt_delegation <= '0;
            cfg_reg.debug_control        <= '0;
            cfg_reg.compressed_enabled   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MTVEC:   cfg_reg.machine_trap_base    <= cfg_data;
                CFG_STVEC:   cfg_reg.super_trap_base      <= cfg_data;
                CFG_MEDELEG: cfg_reg.exception_delegation <= cfg_data;
                CFG_MIDELEG: cfg_reg.interrupt_delegation <= cfg_data;
                CFG_DCSR:    cfg_reg.debug_control        <= cfg_data[31:0];
                CFG_RVC:     cfg_reg.compressed_enabled   <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    tvs_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .req       (request),
        .cfg       (cfg_reg),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    tvs_vector u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .cfg       (cfg_reg),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    tvs_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .out_valid (done),
        .out_data  (result)
    );

    // Every transfer in yields a result after the decode, vector and resolve registers
    `TVS_ASSERT_IMP(a_latency, accept, ##3 done, "accepted request produced no result")
    // Every item in the vector stage is followed by a result
    `TVS_ASSERT_NEXT(a_stage_done, s2_valid, done, "vector stage item lost")
    // Debug entry goes to one of the two entry addresses
    `TVS_ASSERT_IMP(a_debug_addr, done && (result.target_kind == KIND_DEBUG),
        (result.redirect_target == DEBUG_ENTRY) || (result.redirect_target == DEBUG_ENTRY_EXCP),
        "bad debug entry address")
    // Trap vectors are word aligned
    `TVS_ASSERT_IMP(a_trap_align,
        done && ((result.target_kind == KIND_DIRECT) || (result.target_kind == KIND_VECTOR)),
        (result.redirect_target[1:0] == 2'b00), "misaligned trap vector")

endmodule

// File: src/tvs_decode.sv
// First stage: decode the system instruction, cause, debug entry and return PC
module tvs_decode
    import tvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  tvs_req_t req,
    input  tvs_cfg_t cfg,
    output logic     out_valid,
    output tvs_s1_t  out_data
);

    logic    is_call;
    logic    is_break;
    logic    is_ret;
    logic [63:0] cause;
    logic    dbg_en;
    logic    sret;
    logic    dret;
    logic [63:0] epc;
    tvs_s1_t s1_next;
    tvs_s1_t s1_reg;
    logic    valid_reg;

    // Decode the instruction and the effective cause
    always_comb
    begin
        is_call  = req.sys_valid && (req.sys_code == SYS_ECALL);
        is_break = req.sys_valid && (req.sys_code == SYS_EBREAK);
        is_ret   = req.sys_valid && ((req.sys_code == SYS_SRET) || (req.sys_code == SYS_MRET) ||
                   (req.sys_code == SYS_DRET) || (req.sys_code == SYS_XRET));
        if (is_call)
            cause = {56'd0, CAUSE_CALL_BASE + {6'd0, req.priv_level}};
        else if (is_break)
            cause = {56'd0, CAUSE_BREAK};
        else
            cause = req.held_cause;

        // Pick the ebreak enable for the current level
        unique case (req.priv_level)
            PRIV_MACHINE: dbg_en = cfg.debug_control[DCSR_EBREAK_M];
            PRIV_SUPER:   dbg_en = cfg.debug_control[DCSR_EBREAK_S];
            default:      dbg_en = cfg.debug_control[DCSR_EBREAK_U];
        endcase

        // Select and align the return PC
        sret = !req.sys_code[9];
        dret = req.sys_code[10] && req.sys_code[7];
        if (sret)
            epc = req.super_return_pc;
        else if (dret)
            epc = req.debug_return_pc;
        else
            epc = req.machine_return_pc;

        s1_next.ret          = is_ret;
        s1_next.debug        = req.stepped || (cause[7:0] == CAUSE_DEBUG) || req.in_debug ||
                               (!cause[63] && is_break && dbg_en);
        s1_next.debug_excp   = req.in_debug && !is_break;
        s1_next.intr         = cause[63];
        s1_next.may_delegate = (req.priv_level == PRIV_USER) || (req.priv_level == PRIV_SUPER);
        s1_next.lsbs         = cause[7:0];
        s1_next.ret_target   = {epc[63:2], epc[1] & cfg.compressed_enabled, 1'b0};
    end

    // Advance the valid bit; payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            s1_reg <= s1_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = s1_reg;

endmodule

// File: src/tvs_vector.sv
// Second stage: delegation lookup and trap vector base selection
module tvs_vector
    import tvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  tvs_s1_t  in_data,
    input  tvs_cfg_t cfg,
    output logic     out_valid,
    output tvs_s2_t  out_data
);

    logic [63:0] deleg;
    logic        delegate;
    logic [63:0] raw_base;
    logic [63:0] base;
    tvs_s2_t     s2_next;
    tvs_s2_t     s2_reg;
    logic        valid_reg;

    always_comb
    begin
        // Look up the delegation bit; causes whose low eight bits are 64 and up are never delegated
        deleg    = in_data.intr ? cfg.interrupt_delegation : cfg.exception_delegation;
        delegate = in_data.may_delegate && (in_data.lsbs[7:6] == 2'b00) &&
                   deleg[in_data.lsbs[5:0]];

        // Drop the mode bits, then sign-extend a supervisor vector
        raw_base = delegate ? cfg.super_trap_base : cfg.machine_trap_base;
        base     = raw_base & ~(raw_base[0] ? MODE_MASK_VEC : MODE_MASK_DIR);
        if (delegate && base[VADDR_BITS-1])
            base = base | SEXT_MASK;

        s2_next.ret        = in_data.ret;
        s2_next.debug      = in_data.debug;
        s2_next.debug_excp = in_data.debug_excp;
        s2_next.vec_ok     = base[0] && in_data.intr && (in_data.lsbs[7:6] == 2'b00);
        s2_next.vec_code   = in_data.lsbs[5:0];
        s2_next.addr       = in_data.ret ? in_data.ret_target : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            s2_reg <= s2_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = s2_reg;

endmodule

// File: src/tvs_resolve.sv
// Third stage: pick the final target and kind into the result register
module tvs_resolve
    import tvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  tvs_s2_t  in_data,
    output logic     out_valid,
    output tvs_rsp_t out_data
);

    tvs_rsp_t rsp_next;
    tvs_rsp_t rsp_reg;
    logic     valid_reg;

    // Return beats debug entry, debug entry beats a trap
    always_comb
    begin
        priority if (in_data.ret)
        begin
            rsp_next.redirect_target = in_data.addr;
            rsp_next.target_kind     = KIND_RETURN;
        end
        else if (in_data.debug)
        begin
            rsp_next.redirect_target = in_data.debug_excp ? DEBUG_ENTRY_EXCP : DEBUG_ENTRY;
            rsp_next.target_kind     = KIND_DEBUG;
        end
        else if (in_data.vec_ok)
        begin
            rsp_next.redirect_target = {in_data.addr[63:8], in_data.vec_code, 2'b00};
            rsp_next.target_kind     = KIND_VECTOR;
        end
        else
        begin
            rsp_next.redirect_target = {in_data.addr[63:2], 2'b00};
            rsp_next.target_kind     = KIND_DIRECT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            rsp_reg <= rsp_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = rsp_reg;

endmodule
